/* hw/rtl/sitrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit converter package
// Field widths, symbol kind codes and radix limits shared by the converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

    localparam int KIND_W  = 2;
    localparam int DIGIT_W = 4;
    localparam int LEN_W   = 6;
    localparam int RADIX_W = 5;

    // Dividend bits consumed per divider cycle
    localparam int STEP_BITS = 8;

    localparam logic [KIND_W-1:0] KIND_DIGIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MINUS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TERM  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

endpackage

/* hw/rtl/signed_integer_to_radix_digits_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to radix digits
// Converts one signed word to a run of symbols in the configured base:
// optional minus sign, digits most significant first, then a terminator
// that carries the run length.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+----------------------------------
//  s_       | in        | s_valid/s_ready  | s_value
//  m_       | out       | m_valid/m_ready  | m_item_kind, m_digit_value,
//           |           |                  | m_last_item, m_total_length
//  cfg_     | in        | cfg_wr_en        | cfg_wr_data (radix)
//
// Per word: accepted in IDLE, then divided one digit at a time (D digits,
// one 8-bit slice of the dividend per cycle through the shared remainder
// chain), then emitted as an optional sign, D digits and a terminator.
// s_ready is high only in IDLE.
// Reset (synchronous, aresetn low) clears the sequencer and the output valid
// and sets radix to 10. A stalled m_ready holds the output register and the
// emit states; the divider runs on regardless. The terminator is loaded in
// the same cycle as the return to IDLE.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [sitrd_pkg::RADIX_W-1:0]        cfg_wr_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [VALUE_BITS-1:0]         s_value,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [sitrd_pkg::KIND_W-1:0]         m_item_kind,
    output logic [sitrd_pkg::DIGIT_W-1:0]        m_digit_value,
    output logic                                 m_last_item,
    output logic [sitrd_pkg::LEN_W-1:0]          m_total_length
);

    import sitrd_pkg::*;

    // Dividend padded to whole slices
    localparam int QW     = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS  = QW / STEP_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int STK_W  = VALUE_BITS * DIGIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGIT,
        ST_TERM
    } state_t;

    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic                   neg_reg, neg_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [STK_W-1:0]       stk_reg, stk_next;

    logic                   m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]      m_kind_reg, m_kind_next;
    logic [DIGIT_W-1:0]     m_digit_reg, m_digit_next;
    logic                   m_last_reg, m_last_next;
    logic [LEN_W-1:0]       m_len_reg, m_len_next;

    logic [VALUE_BITS-1:0]  val_u;
    logic [VALUE_BITS-1:0]  mag;
    logic [RADIX_W-1:0]     base_clamped;
    logic [STEP_BITS-1:0]   qbits;
    logic [DIGIT_W-1:0]     rem_step;
    logic [QW-1:0]          quo_shifted;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   out_load;

    // Magnitude as unsigned: the most negative value maps to 2^(VALUE_BITS-1)
    assign val_u = $unsigned(s_value);
    assign mag   = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;

    // Bases outside 2..16 fold onto the nearest limit
    assign base_clamped = (radix_reg < RADIX_MIN) ? RADIX_MIN :
                          (radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg;

    // Shared remainder chain: eight restoring steps on a 4-bit remainder,
    // one slice of the dividend per cycle, quotient bits shift in below.
    always_comb begin
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {r, quo_reg[QW-1-i]};
            if (trial >= base_reg) begin
                trial              = trial - base_reg;
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        rem_step = r;
    end

    assign quo_shifted = (quo_reg << STEP_BITS) | QW'(qbits);
    assign cnt_inc     = cnt_reg + CNT_W'(1);

    // Output register takes a new word when empty or being drained
    assign out_load = ~m_valid_reg | m_ready;

    always_comb begin
        state_next   = state_reg;
        radix_next   = radix_reg;
        base_next    = base_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        stk_next     = stk_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_digit_next = m_digit_reg;
        m_last_next  = m_last_reg;
        m_len_next   = m_len_reg;

        if (cfg_wr_en) begin
            radix_next = cfg_wr_data;
        end

        // Drop the word once taken; a load below overrides
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next  = base_clamped;
                    neg_next   = val_u[VALUE_BITS-1];
                    quo_next   = QW'(mag);
                    rem_next   = '0;
                    step_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                quo_next  = quo_shifted;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    // Digit done: push it, then stop on a zero quotient
                    stk_next  = {stk_reg[STK_W-DIGIT_W-1:0], rem_step};
                    cnt_next  = cnt_inc;
                    rem_next  = '0;
                    step_next = '0;
                    if (quo_shifted == '0) begin
                        len_next   = LEN_W'(cnt_inc) + LEN_W'(neg_reg) + LEN_W'(1);
                        state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_MINUS;
                    m_digit_next = '0;
                    m_last_next  = 1'b0;
                    m_len_next   = '0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_load) begin
                    // Pop the most recent digit, which is the most significant
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DIGIT;
                    m_digit_next = stk_reg[DIGIT_W-1:0];
                    m_last_next  = 1'b0;
                    m_len_next   = '0;
                    stk_next     = {{DIGIT_W{1'b0}}, stk_reg[STK_W-1:DIGIT_W]};
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_TERM;
                    m_digit_next = '0;
                    m_last_next  = 1'b1;
                    m_len_next   = len_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            m_valid_reg <= m_valid_next;
        end
        base_reg    <= base_next;
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        cnt_reg     <= cnt_next;
        len_reg     <= len_next;
        stk_reg     <= stk_next;
        m_kind_reg  <= m_kind_next;
        m_digit_reg <= m_digit_next;
        m_last_reg  <= m_last_next;
        m_len_reg   <= m_len_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_item_kind    = m_kind_reg;
    assign m_digit_value  = m_digit_reg;
    assign m_last_item    = m_last_reg;
    assign m_total_length = m_len_reg;

endmodule
